/* rtl/lppe_pkg.sv */
// Types and constants shared by the LED pixel pulse encoder modules.
package lppe_pkg;

   localparam int unsigned TICK_W  = 15;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned STEP_W  = 6;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bit steps per pixel for three and four byte pixels.
   localparam logic [STEP_W-1:0] STEPS_GRB  = 6'd24;
   localparam logic [STEP_W-1:0] STEPS_GRBW = 6'd32;

   // Register indexes on the configuration port.
   localparam logic [INDEX_W-1:0] REG_BYTES_PER_PIXEL = 3'd0;
   localparam logic [INDEX_W-1:0] REG_ZERO_HIGH       = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ZERO_LOW        = 3'd2;
   localparam logic [INDEX_W-1:0] REG_ONE_HIGH        = 3'd3;
   localparam logic [INDEX_W-1:0] REG_ONE_LOW         = 3'd4;
   localparam logic [INDEX_W-1:0] REG_LATCH           = 3'd5;
   localparam logic [INDEX_W-1:0] REG_ITEM_LIMIT      = 3'd6;

   // Register reset values.
   localparam logic [2:0]         RST_BYTES_PER_PIXEL = 3'd3;
   localparam logic [TICK_W-1:0]  RST_ZERO_HIGH       = 15'd8;
   localparam logic [TICK_W-1:0]  RST_ZERO_LOW        = 15'd17;
   localparam logic [TICK_W-1:0]  RST_ONE_HIGH        = 15'd17;
   localparam logic [TICK_W-1:0]  RST_ONE_LOW         = 15'd8;
   localparam logic [TICK_W-1:0]  RST_LATCH           = 15'd1000;
   localparam logic [COUNT_W-1:0] RST_ITEM_LIMIT      = 16'd1024;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] low_ticks;
      logic              bit_value;
      logic              last_item;
   } pulse_type;

   typedef struct packed {
      logic [2:0]         bytes_per_pixel;
      logic [TICK_W-1:0]  zero_high_ticks;
      logic [TICK_W-1:0]  zero_low_ticks;
      logic [TICK_W-1:0]  one_high_ticks;
      logic [TICK_W-1:0]  one_low_ticks;
      logic [TICK_W-1:0]  latch_ticks;
      logic [COUNT_W-1:0] item_limit;
   } cfg_type;

   // One classified step between front and back: a data bit or a frame end.
   typedef struct packed {
      logic bit_value;
      logic frame_end;
   } step_type;

endpackage

/* rtl/lppe_queue.sv */
// Short queue of classified steps between the front and back parts.
module lppe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lppe_pkg::step_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output lppe_pkg::step_type head
);

   lppe_pkg::step_type entry_ff [lppe_pkg::QUEUE_DEPTH];

   logic [lppe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lppe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lppe_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [lppe_pkg::QCNT_W-1:0] DEPTH_CNT =
      lppe_pkg::QCNT_W'(lppe_pkg::QUEUE_DEPTH);
   localparam logic [lppe_pkg::QPTR_W-1:0] LAST_PTR =
      lppe_pkg::QPTR_W'(lppe_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      full      = (count_ff == DEPTH_CNT);
      not_empty = (count_ff != '0);
      head      = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue read while empty");

endmodule

/* rtl/lppe_front.sv */
// Front part: accepts pixels, walks their bits in send order and applies the item limit.
module lppe_front (
   input  logic               clock,
   input  logic               reset,
   input  lppe_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  lppe_pkg::pixel_type req_data,
   input  logic               q_full,
   output logic               q_push,
   output lppe_pkg::step_type q_data
);

   logic [31:0]                  data_ff, data_in;
   logic [lppe_pkg::STEP_W-1:0]  remain_ff, remain_in;
   logic                         end_ff, end_in;
   logic [lppe_pkg::COUNT_W-1:0] count_ff, count_in;

   logic busy;
   logic step;
   logic bit_step;
   logic last_step;
   logic under_limit;
   logic accept;

   always_comb begin
      busy        = (remain_ff != '0) || end_ff;
      step        = busy && !q_full;
      bit_step    = (remain_ff != '0);
      last_step   = ((remain_ff == lppe_pkg::STEP_W'(1)) && !end_ff) || !bit_step;
      under_limit = (count_ff < cfg.item_limit);
      req_stall   = busy && !(step && last_step);
      accept      = req_valid && !req_stall;

      q_push           = step && (!bit_step || under_limit);
      q_data.bit_value = bit_step ? data_ff[31] : 1'b0;
      q_data.frame_end = !bit_step;

      data_in   = data_ff;
      remain_in = remain_ff;
      end_in    = end_ff;
      count_in  = count_ff;

      if (step) begin
         if (bit_step) begin
            data_in   = {data_ff[30:0], 1'b0};
            remain_in = remain_ff - 1'b1;
            if (under_limit) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            // frame end: restart the count for the next frame
            end_in   = 1'b0;
            count_in = '0;
         end
      end

      if (accept) begin
         data_in   = {req_data.byte1, req_data.byte0, req_data.byte2, req_data.byte3};
         remain_in = cfg.bytes_per_pixel[2] ? lppe_pkg::STEPS_GRBW : lppe_pkg::STEPS_GRB;
         end_in    = req_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         end_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         remain_ff <= remain_in;
         end_ff    <= end_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (remain_ff == lppe_pkg::STEPS_GRB) || (remain_ff == lppe_pkg::STEPS_GRBW))
      else $error("accepted pixel did not load its bit steps");

endmodule

/* rtl/lppe_back.sv */
// Back part: holds back the newest bit and emits pulse items with current timing.
module lppe_back (
   input  logic               clock,
   input  logic               reset,
   input  lppe_pkg::cfg_type  cfg,
   input  logic               q_not_empty,
   input  lppe_pkg::step_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lppe_pkg::pulse_type rsp_data
);

   logic                held_valid_ff, held_valid_in;
   logic                held_bit_ff, held_bit_in;
   logic                out_valid_ff, out_valid_in;
   lppe_pkg::pulse_type out_ff, out_in;

   logic out_free;
   logic load;

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      // a step with nothing held emits nothing, so it never waits on the output
      q_pop    = q_not_empty && (!held_valid_ff || out_free);
      load     = q_pop && held_valid_ff;

      held_valid_in = held_valid_ff;
      held_bit_in   = held_bit_ff;
      if (q_pop) begin
         if (q_head.frame_end) begin
            held_valid_in = 1'b0;
            held_bit_in   = 1'b0;
         end else begin
            held_valid_in = 1'b1;
            held_bit_in   = q_head.bit_value;
         end
      end

      out_in.bit_value  = held_bit_ff;
      out_in.last_item  = q_head.frame_end;
      out_in.high_ticks = held_bit_ff ? cfg.one_high_ticks : cfg.zero_high_ticks;
      if (q_head.frame_end) begin
         out_in.low_ticks = cfg.latch_ticks;
      end else begin
         out_in.low_ticks = held_bit_ff ? cfg.one_low_ticks : cfg.zero_low_ticks;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_valid = out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bit_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bit_ff   <= held_bit_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.frame_end) |=> !held_valid_ff)
      else $error("held item survived a frame end");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("emitted item not presented");

endmodule

/* rtl/led_pixel_pulse_encoder_unit.sv */
// Each bit passes the front shift register, the step queue, the held bit and the output register.
// Throughput: one pulse item per cycle while the receiver does not stall and under the item limit.
// The front part's bit walk sets the pace; the back part drains one step a cycle unless stalled.
// The newest item of a frame stays held until the next bit or the frame end releases it.
// Reset (synchronous) restores register defaults, clears the count, queue and held item.
module led_pixel_pulse_encoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lppe_pkg::pixel_type           req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lppe_pkg::pulse_type           rsp_data,
   input  logic                          csr_wr_en,
   input  logic [lppe_pkg::INDEX_W-1:0]  csr_index,
   input  logic [lppe_pkg::DATA_W-1:0]   csr_wdata
);

   lppe_pkg::cfg_type  cfg_ff, cfg_in;
   lppe_pkg::step_type push_data;
   lppe_pkg::step_type head;
   logic               push;
   logic               pop;
   logic               full;
   logic               not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lppe_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            lppe_pkg::REG_ZERO_HIGH:       cfg_in.zero_high_ticks = csr_wdata[14:0];
            lppe_pkg::REG_ZERO_LOW:        cfg_in.zero_low_ticks  = csr_wdata[14:0];
            lppe_pkg::REG_ONE_HIGH:        cfg_in.one_high_ticks  = csr_wdata[14:0];
            lppe_pkg::REG_ONE_LOW:         cfg_in.one_low_ticks   = csr_wdata[14:0];
            lppe_pkg::REG_LATCH:           cfg_in.latch_ticks     = csr_wdata[14:0];
            lppe_pkg::REG_ITEM_LIMIT:      cfg_in.item_limit      = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= lppe_pkg::RST_BYTES_PER_PIXEL;
         cfg_ff.zero_high_ticks <= lppe_pkg::RST_ZERO_HIGH;
         cfg_ff.zero_low_ticks  <= lppe_pkg::RST_ZERO_LOW;
         cfg_ff.one_high_ticks  <= lppe_pkg::RST_ONE_HIGH;
         cfg_ff.one_low_ticks   <= lppe_pkg::RST_ONE_LOW;
         cfg_ff.latch_ticks     <= lppe_pkg::RST_LATCH;
         cfg_ff.item_limit      <= lppe_pkg::RST_ITEM_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lppe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (full),
      .q_push    (push),
      .q_data    (push_data)
   );

   lppe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   lppe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* verif/tb_led_pixel_pulse_encoder_unit.sv */
// Testbench for the LED pixel pulse encoder unit: pixel frames checked against a local predictor.
module tb_led_pixel_pulse_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 300;
   localparam int PHASE_ITEMS   = 30;
   localparam logic [lppe_pkg::INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_e;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   lppe_pkg::pixel_type          req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   lppe_pkg::pulse_type          rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [lppe_pkg::INDEX_W-1:0] csr_index = '0;
   logic [lppe_pkg::DATA_W-1:0]  csr_wdata = '0;

   logic              req_taken = 1'b0;
   int                fail_count = 0;

   lppe_pkg::pixel_type pixel_queue[$];
   lppe_pkg::pulse_type pulse_expect_q[$];

   // Register copy, reset values
   logic [2:0]                   cfg_bytes     = lppe_pkg::RST_BYTES_PER_PIXEL;
   logic [lppe_pkg::TICK_W-1:0]  cfg_zero_high = lppe_pkg::RST_ZERO_HIGH;
   logic [lppe_pkg::TICK_W-1:0]  cfg_zero_low  = lppe_pkg::RST_ZERO_LOW;
   logic [lppe_pkg::TICK_W-1:0]  cfg_one_high  = lppe_pkg::RST_ONE_HIGH;
   logic [lppe_pkg::TICK_W-1:0]  cfg_one_low   = lppe_pkg::RST_ONE_LOW;
   logic [lppe_pkg::TICK_W-1:0]  cfg_latch     = lppe_pkg::RST_LATCH;
   logic [lppe_pkg::COUNT_W-1:0] cfg_limit     = lppe_pkg::RST_ITEM_LIMIT;

   // Encoder state
   logic [lppe_pkg::COUNT_W-1:0] frame_count = '0;
   logic                         hold_valid  = 1'b0;
   logic                         hold_bit    = 1'b0;

   led_pixel_pulse_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic lppe_pkg::pulse_type make_pulse(logic b, logic is_final);
      lppe_pkg::pulse_type p;
      p.high_ticks = b ? cfg_one_high : cfg_zero_high;
      p.low_ticks  = is_final ? cfg_latch : (b ? cfg_one_low : cfg_zero_low);
      p.bit_value  = b;
      p.last_item  = is_final;
      return p;
   endfunction

   // Turn one accepted pixel into the pulse items it releases.
   task automatic encode_pixel(input lppe_pkg::pixel_type px);
      logic [7:0] order[4];
      logic       bit_list[$];
      int         nbytes;
      order[0] = px.byte1;
      order[1] = px.byte0;
      order[2] = px.byte2;
      order[3] = px.byte3;
      nbytes = (cfg_bytes >= 3'd4) ? 4 : 3;
      if (hold_valid) bit_list.push_back(hold_bit);
      for (int b = 0; b < nbytes; b++) begin
         for (int k = 7; k >= 0; k--) begin
            // drop bits past the per-frame limit
            if (frame_count < cfg_limit) begin
               bit_list.push_back(order[b][k]);
               frame_count = frame_count + 1'b1;
            end
         end
      end
      if (px.last_pixel) begin
         for (int i = 0; i < bit_list.size(); i++)
            pulse_expect_q.push_back(make_pulse(bit_list[i], i == bit_list.size() - 1));
         frame_count = '0;
         hold_valid  = 1'b0;
         hold_bit    = 1'b0;
      end else if (bit_list.size() != 0) begin
         for (int i = 0; i < bit_list.size() - 1; i++)
            pulse_expect_q.push_back(make_pulse(bit_list[i], 1'b0));
         hold_valid = 1'b1;
         hold_bit   = bit_list[bit_list.size() - 1];
      end
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic write_reg(logic [lppe_pkg::INDEX_W-1:0] idx,
                            logic [lppe_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         lppe_pkg::REG_BYTES_PER_PIXEL: cfg_bytes     = data[2:0];
         lppe_pkg::REG_ZERO_HIGH:       cfg_zero_high = data[lppe_pkg::TICK_W-1:0];
         lppe_pkg::REG_ZERO_LOW:        cfg_zero_low  = data[lppe_pkg::TICK_W-1:0];
         lppe_pkg::REG_ONE_HIGH:        cfg_one_high  = data[lppe_pkg::TICK_W-1:0];
         lppe_pkg::REG_ONE_LOW:         cfg_one_low   = data[lppe_pkg::TICK_W-1:0];
         lppe_pkg::REG_LATCH:           cfg_latch     = data[lppe_pkg::TICK_W-1:0];
         lppe_pkg::REG_ITEM_LIMIT:      cfg_limit     = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_ticks(logic [lppe_pkg::DATA_W-1:0] zh, logic [lppe_pkg::DATA_W-1:0] zl,
                              logic [lppe_pkg::DATA_W-1:0] oh, logic [lppe_pkg::DATA_W-1:0] ol,
                              logic [lppe_pkg::DATA_W-1:0] lt);
      write_reg(lppe_pkg::REG_ZERO_HIGH, zh);
      write_reg(lppe_pkg::REG_ZERO_LOW, zl);
      write_reg(lppe_pkg::REG_ONE_HIGH, oh);
      write_reg(lppe_pkg::REG_ONE_LOW, ol);
      write_reg(lppe_pkg::REG_LATCH, lt);
   endtask

   task automatic queue_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [7:0] b3, logic last);
      lppe_pkg::pixel_type px;
      px.byte0      = b0;
      px.byte1      = b1;
      px.byte2      = b2;
      px.byte3      = b3;
      px.last_pixel = last;
      pixel_queue.push_back(px);
   endtask

   // Hold until every pixel is taken and every pulse item has come, then let the walk finish.
   task automatic settle_block();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || pulse_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_regs();
      int pick;
      int limit_pick;
      logic [lppe_pkg::DATA_W-1:0] limit_value;
      pick = $urandom_range(0, 9);
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, {13'($urandom_range(0, 8191)),
                (pick < 4) ? 3'd3 : (pick < 8) ? 3'd4 : 3'($urandom_range(0, 7))});
      write_ticks(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      limit_pick = $urandom_range(0, 9);
      if (limit_pick < 5)      limit_value = lppe_pkg::RST_ITEM_LIMIT;
      else if (limit_pick < 7) limit_value = 16'($urandom_range(0, 40));
      else if (limit_pick < 8) limit_value = 16'hFFFF;
      else                     limit_value = 16'($urandom_range(0, 65535));
      write_reg(lppe_pkg::REG_ITEM_LIMIT, limit_value);
   endtask

   // Monitor: take pixels into the predictor and check pulse items in order.
   always @(posedge clock) begin
      lppe_pkg::pulse_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         encode_pixel(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulse_expect_q.size() == 0) begin
            report("unexpected item, bit_value", 32'(rsp_data.bit_value), 0);
         end else begin
            want = pulse_expect_q.pop_front();
            if (rsp_data.high_ticks !== want.high_ticks)
               report("high_ticks", 32'(rsp_data.high_ticks), 32'(want.high_ticks));
            if (rsp_data.low_ticks !== want.low_ticks)
               report("low_ticks", 32'(rsp_data.low_ticks), 32'(want.low_ticks));
            if (rsp_data.bit_value !== want.bit_value)
               report("bit_value", 32'(rsp_data.bit_value), 32'(want.bit_value));
            if (rsp_data.last_item !== want.last_item)
               report("last_item", 32'(rsp_data.last_item), 32'(want.last_item));
         end
      end
   end

   // Driver: bursts of pixels with random gaps between them.
   int burst_left = 0;
   int gap_left   = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_data  <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: modes switch every so often.
   stall_mode_e stall_mode = STALL_NONE;
   int          mode_left  = 0;
   int          stall_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_e'($urandom_range(0, 2));
         mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_left == 0 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 8);
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
         end
      endcase
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int random_sent;
      int phase_items;
      int len;
      bit closed;
      random_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zeros, ones, byte order, single-pixel frame
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'hA5, 8'h3C, 8'h0F, 8'hF0, 1'b1);
      queue_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
      settle_block();

      // Four-byte pixels, tick extremes, widest limit
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, 16'd4);
      write_ticks(16'd0, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF);
      write_reg(lppe_pkg::REG_ITEM_LIMIT, 16'hFFFF);
      write_reg(REG_UNUSED, 16'hFFFF);
      queue_pixel(8'hFF, 8'h00, 8'hAA, 8'h55, 1'b0);
      queue_pixel(8'h01, 8'h80, 8'h7E, 8'h81, 1'b1);
      settle_block();

      // Undersized pixel setting, limit reached mid-pixel, zero latch
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, 16'd0);
      write_reg(lppe_pkg::REG_ITEM_LIMIT, 16'd5);
      write_ticks(16'd8, 16'd17, 16'd17, 16'd8, 16'd0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      settle_block();

      // Zero limit: empty frame ends
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, 16'hFFFF);
      write_reg(lppe_pkg::REG_ITEM_LIMIT, 16'd0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_pixel(8'hAA, 8'hAA, 8'hAA, 8'hAA, 1'b0);
      queue_pixel(8'h55, 8'h55, 8'h55, 8'h55, 1'b1);
      settle_block();

      // Held item must pick up timing written while it waits
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, 16'd4);
      write_reg(lppe_pkg::REG_ITEM_LIMIT, lppe_pkg::RST_ITEM_LIMIT);
      write_ticks(16'd3, 16'd4, 16'd5, 16'd6, 16'd7);
      queue_pixel(8'hC3, 8'h3C, 8'h99, 8'h66, 1'b0);
      settle_block();
      write_ticks(16'd100, 16'd200, 16'd300, 16'd400, 16'd500);
      queue_pixel(8'h5A, 8'hA5, 8'hF0, 8'h0F, 1'b1);
      settle_block();

      // Limit exactly one three-byte pixel
      write_reg(lppe_pkg::REG_BYTES_PER_PIXEL, 16'd3);
      write_reg(lppe_pkg::REG_ITEM_LIMIT, 16'd24);
      queue_pixel(8'h0F, 8'hF0, 8'h3C, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      settle_block();

      while (random_sent < RANDOM_ITEMS) begin
         random_regs();
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            len    = $urandom_range(1, 6);
            // leave some frames open so the held item carries on
            closed = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++)
               queue_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           closed && (i == len - 1));
            phase_items += len;
            if ($urandom_range(0, 7) == 0) settle_block();
         end
         random_sent += phase_items;
         settle_block();
      end

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* led_pixel_pulse_encoder_unit.f */
rtl/lppe_pkg.sv
rtl/lppe_queue.sv
rtl/lppe_front.sv
rtl/lppe_back.sv
rtl/led_pixel_pulse_encoder_unit.sv
verif/tb_led_pixel_pulse_encoder_unit.sv
